// File: rtl/crc8pr_pkg.sv
// Shared types, constants and the CRC-8 step function of the packet receiver.
package crc8pr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
    localparam int MEM_AW      = PAY_AW + 1;
    localparam int MEM_DEPTH   = 2 * MAX_PAYLOAD;

    localparam int JOBQ_AW    = 1;
    localparam int JOBQ_DEPTH = 1 << JOBQ_AW;
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_DEPTH = 1 << OUTQ_AW;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CRC      = 3'd1;
    localparam logic [2:0] ST_ADDR     = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [5:0] POS_HUNT = 6'd0;
    localparam logic [5:0] POS_RCV  = 6'd1;
    localparam logic [5:0] POS_SND  = 6'd2;
    localparam logic [5:0] POS_CMD  = 6'd3;
    localparam logic [5:0] POS_LEN  = 6'd4;
    localparam logic [5:0] POS_DATA = 6'd5;

    localparam logic [1:0] CFG_START   = 2'd0;
    localparam logic [1:0] CFG_OWN     = 2'd1;
    localparam logic [1:0] CFG_BCAST   = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT = 2'd3;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  own_address;
        logic [7:0]  broadcast_address;
        logic [15:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic       is_frame;
        logic [2:0] status;
        logic [7:0] receiver_id;
        logic [7:0] sender_id;
        logic [7:0] command_code;
        logic [5:0] data_length;
        logic       bank;
    } t_job;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] receiver_id;
        logic [7:0] sender_id;
        logic [7:0] command_code;
        logic [5:0] data_length;
        logic [4:0] data_index;
        logic [7:0] data_value;
        logic       last;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    typedef struct packed {
        logic en;
        logic bank;
    } t_release;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc_in;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = {1'b0, c[7:1]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/crc8_packet_receiver_unit.sv
// Top level: configuration registers and the parser, job queue and emitter.
//
//  channel  direction  handshake            payload
//  input    in         push / full          i_command, i_rx_byte
//  result   out        empty / pop          o_status .. o_last
//  config   in         i_cfg_we (no wait)   i_cfg_idx, i_cfg_data
//
//  The parser takes one transaction per cycle while full is low; a tick or a byte is
//  handled in that cycle. A good frame of N data bytes yields max(N,1) results, one per
//  cycle from the emitter while its output queue has room; each status result is one
//  transaction. full rises while the job queue is full or the payload bank to be filled
//  next is still being read out by the emitter (two banks of 32 bytes).
//  Synchronous reset clears control state; payload memory needs no clearing pass.
module crc8_packet_receiver_unit import crc8pr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [7:0]  o_receiver_id,
    output logic [7:0]  o_sender_id,
    output logic [7:0]  o_command_code,
    output logic [5:0]  o_data_length,
    output logic [4:0]  o_data_index,
    output logic [7:0]  o_data_value,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     jobq_full;
    logic     jobq_empty;
    logic     jobq_pop;
    logic     job_push;
    t_job     job_in;
    t_job     job_head;
    t_mem_wr  mem_wr;
    t_release release_bank;
    t_result  head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker      <= 8'd255;
            r_cfg.own_address       <= 8'd0;
            r_cfg.broadcast_address <= 8'd254;
            r_cfg.timeout_ticks     <= 16'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START:   r_cfg.start_marker      <= i_cfg_data[7:0];
                CFG_OWN:     r_cfg.own_address       <= i_cfg_data[7:0];
                CFG_BCAST:   r_cfg.broadcast_address <= i_cfg_data[7:0];
                CFG_TIMEOUT: r_cfg.timeout_ticks     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    crc8pr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_command   (i_command),
        .i_rx_byte   (i_rx_byte),
        .o_full      (full),
        .i_cfg       (r_cfg),
        .i_jobq_full (jobq_full),
        .o_job_push  (job_push),
        .o_job       (job_in),
        .o_mem_wr    (mem_wr),
        .i_release   (release_bank)
    );

    crc8pr_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (jobq_full),
        .i_pop   (jobq_pop),
        .o_empty (jobq_empty),
        .o_head  (job_head)
    );

    crc8pr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mem_wr     (mem_wr),
        .i_jobq_empty (jobq_empty),
        .i_job        (job_head),
        .o_jobq_pop   (jobq_pop),
        .o_release    (release_bank),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_head       (head)
    );

    assign o_status       = head.status;
    assign o_receiver_id  = head.receiver_id;
    assign o_sender_id    = head.sender_id;
    assign o_command_code = head.command_code;
    assign o_data_length  = head.data_length;
    assign o_data_index   = head.data_index;
    assign o_data_value   = head.data_value;
    assign o_last         = head.last;

endmodule

// File: rtl/crc8pr_front.sv
// Frame parser: tracks position, CRC and timeout, fills payload banks, posts jobs.
module crc8pr_front import crc8pr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  logic     i_command,
    input  logic [7:0] i_rx_byte,
    output logic     o_full,
    input  t_cfg     i_cfg,
    input  logic     i_jobq_full,
    output logic     o_job_push,
    output t_job     o_job,
    output t_mem_wr  o_mem_wr,
    input  t_release i_release
);

    logic [5:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_elapsed, n_elapsed;
    logic [7:0]  r_rcv, n_rcv;
    logic [7:0]  r_snd, n_snd;
    logic [7:0]  r_cmd, n_cmd;
    logic [5:0]  r_len, n_len;
    logic        r_bank, n_bank;
    logic [1:0]  r_busy, n_busy;

    logic        accept;
    logic [5:0]  pos_off;
    logic [7:0]  crc_next;
    logic [7:0]  crc_start;

    assign o_full    = i_jobq_full | r_busy[r_bank];
    assign accept    = i_push & ~o_full;
    assign pos_off   = r_pos - POS_DATA;
    assign crc_next  = crc8_byte(r_crc, i_rx_byte);
    assign crc_start = crc8_byte(8'h00, i_cfg.start_marker);

    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_elapsed = r_elapsed;
        n_rcv     = r_rcv;
        n_snd     = r_snd;
        n_cmd     = r_cmd;
        n_len     = r_len;
        n_bank    = r_bank;
        n_busy    = r_busy;

        o_job_push         = 1'b0;
        o_job.is_frame     = 1'b0;
        o_job.status       = ST_OK;
        o_job.receiver_id  = r_rcv;
        o_job.sender_id    = r_snd;
        o_job.command_code = r_cmd;
        o_job.data_length  = r_len;
        o_job.bank         = r_bank;

        o_mem_wr.en   = 1'b0;
        o_mem_wr.addr = {r_bank, pos_off[PAY_AW-1:0]};
        o_mem_wr.data = i_rx_byte;

        if (i_release.en) begin
            n_busy[i_release.bank] = 1'b0;
        end

        if (accept) begin
            if (i_command == CMD_TICK) begin
                if (r_pos != POS_HUNT) begin
                    if (r_elapsed >= i_cfg.timeout_ticks) begin
                        o_job_push   = 1'b1;
                        o_job.status = ST_TIMEOUT;
                        n_pos        = POS_HUNT;
                        n_crc        = 8'h00;
                        n_elapsed    = 16'd0;
                    end else begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                end
            end else begin
                case (r_pos)
                    POS_HUNT: begin
                        if (i_rx_byte == i_cfg.start_marker) begin
                            n_pos     = POS_RCV;
                            n_crc     = crc_start;
                            n_elapsed = 16'd0;
                        end
                    end
                    POS_RCV, POS_SND: begin
                        // a marker in an address slot restarts the frame
                        if (i_rx_byte == i_cfg.start_marker) begin
                            n_pos     = POS_RCV;
                            n_crc     = crc_start;
                            n_elapsed = 16'd0;
                        end else begin
                            if (r_pos == POS_RCV) begin
                                n_rcv = i_rx_byte;
                            end else begin
                                n_snd = i_rx_byte;
                            end
                            n_crc = crc_next;
                            n_pos = r_pos + 6'd1;
                        end
                    end
                    POS_CMD: begin
                        n_cmd = i_rx_byte;
                        n_crc = crc_next;
                        n_pos = POS_LEN;
                    end
                    POS_LEN: begin
                        if (i_rx_byte > 8'(MAX_PAYLOAD)) begin
                            o_job_push   = 1'b1;
                            o_job.status = ST_OVERFLOW;
                            n_pos        = POS_HUNT;
                            n_crc        = 8'h00;
                            n_elapsed    = 16'd0;
                        end else begin
                            n_len = i_rx_byte[5:0];
                            n_crc = crc_next;
                            n_pos = POS_DATA;
                        end
                    end
                    default: begin
                        if (r_pos < POS_DATA + r_len) begin
                            o_mem_wr.en = 1'b1;
                            n_crc       = crc_next;
                            n_pos       = r_pos + 6'd1;
                        end else begin
                            o_job_push = 1'b1;
                            n_pos      = POS_HUNT;
                            n_crc      = 8'h00;
                            n_elapsed  = 16'd0;
                            if (i_rx_byte != r_crc) begin
                                o_job.status = ST_CRC;
                            end else if (r_rcv != i_cfg.own_address &&
                                         r_rcv != i_cfg.broadcast_address) begin
                                o_job.status = ST_ADDR;
                            end else begin
                                // hand the bank to the back end, fill the other one next
                                o_job.is_frame = 1'b1;
                                n_busy[r_bank] = 1'b1;
                                n_bank         = ~r_bank;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_HUNT;
            r_crc     <= 8'h00;
            r_elapsed <= 16'd0;
            r_bank    <= 1'b0;
            r_busy    <= 2'b00;
        end else begin
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_elapsed <= n_elapsed;
            r_bank    <= n_bank;
            r_busy    <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rcv <= n_rcv;
        r_snd <= n_snd;
        r_cmd <= n_cmd;
        r_len <= n_len;
    end

endmodule

// File: rtl/crc8pr_jobq.sv
// Short job queue between the parser and the result emitter.
module crc8pr_jobq import crc8pr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    t_job               r_q [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0] r_wr, r_rd;
    logic [JOBQ_AW:0]   r_cnt, n_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == (JOBQ_AW+1)'(JOBQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_q[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= i_job;
        end
    end

endmodule

// File: rtl/crc8pr_back.sv
// Result emitter: payload memory, per-byte result generation and output queue.
module crc8pr_back import crc8pr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_wr  i_mem_wr,
    input  logic     i_jobq_empty,
    input  t_job     i_job,
    output logic     o_jobq_pop,
    output t_release o_release,
    input  logic     i_pop,
    output logic     o_empty,
    output t_result  o_head
);

    logic [7:0]         r_mem [MEM_DEPTH];
    logic [7:0]         r_rd_data;

    logic               r_act;
    t_job               r_job;
    logic [PAY_AW-1:0]  r_idx;
    logic               r_pend_v;
    logic               r_pend_zero;
    t_result            r_pend_res;

    t_result            r_oq [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_wr, r_rd;
    logic [OUTQ_AW:0]   r_cnt, n_cnt;

    logic [PAY_AW-1:0]  last_idx;
    logic               is_last;
    logic               can_issue;
    logic               issue;
    logic               take;
    logic               do_pop;
    logic [5:0]         len_m1;
    t_result            issue_res;
    t_result            push_res;

    assign len_m1    = r_job.data_length - 6'd1;
    assign last_idx  = (r_job.data_length == 6'd0) ? '0 : len_m1[PAY_AW-1:0];
    assign is_last   = ~r_job.is_frame | (r_idx == last_idx);
    // reserve a slot for the result whose payload read is in flight
    assign can_issue = ({1'b0, r_cnt} + {{(OUTQ_AW+1){1'b0}}, r_pend_v})
                       < (OUTQ_AW+2)'(OUTQ_DEPTH);
    assign issue     = r_act & can_issue;
    assign take      = ~i_jobq_empty & (~r_act | (issue & is_last));
    assign o_jobq_pop = take;

    assign o_release.en   = issue & is_last & r_job.is_frame;
    assign o_release.bank = r_job.bank;

    always_comb begin
        issue_res.status     = r_job.status;
        issue_res.last       = is_last;
        issue_res.data_value = 8'h00;
        if (r_job.is_frame) begin
            issue_res.receiver_id  = r_job.receiver_id;
            issue_res.sender_id    = r_job.sender_id;
            issue_res.command_code = r_job.command_code;
            issue_res.data_length  = r_job.data_length;
            issue_res.data_index   = 5'(r_idx);
        end else begin
            issue_res.receiver_id  = 8'h00;
            issue_res.sender_id    = 8'h00;
            issue_res.command_code = 8'h00;
            issue_res.data_length  = 6'd0;
            issue_res.data_index   = 5'd0;
        end
    end

    always_comb begin
        push_res            = r_pend_res;
        push_res.data_value = r_pend_zero ? 8'h00 : r_rd_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        end
        if (issue) begin
            r_rd_data <= r_mem[{r_job.bank, r_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_pend_v <= issue;
            if (take) begin
                r_act <= 1'b1;
            end else if (issue && is_last) begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_job;
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= r_idx + 1'b1;
        end
        if (issue) begin
            r_pend_res  <= issue_res;
            r_pend_zero <= ~r_job.is_frame | (r_job.data_length == 6'd0);
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_head  = r_oq[r_rd];
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (r_pend_v && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !r_pend_v) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (r_pend_v) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend_v) begin
            r_oq[r_wr] <= push_res;
        end
    end

endmodule
